FILE: src/rc4_keystream_cipher_macros.svh
// ----------------------------------------------------------------------------
// rc4 keystream cipher assertion macros
// shared concurrent assertion wrappers, clocked on aclk, off during reset
// ----------------------------------------------------------------------------
`ifndef RC4_KEYSTREAM_CIPHER_MACROS_SVH
`define RC4_KEYSTREAM_CIPHER_MACROS_SVH

// same-cycle implication
`define RC4_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define RC4_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/rc4_pkg.sv
// ----------------------------------------------------------------------------
// rc4_pkg
// shared constants and types for the rc4 keystream cipher
// ----------------------------------------------------------------------------
package rc4_pkg;

    localparam int MAX_KEY_BYTES = 16;
    localparam int KEY_LEN_W     = 5;
    localparam int KEY_HALF_W    = 64;
    localparam int CFG_ADDR_W    = 2;
    localparam int CFG_DATA_W    = 64;

    localparam logic [CFG_ADDR_W-1:0] REG_KEY_HEAD   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_KEY_TAIL   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_KEY_LENGTH = 2'd2;

    localparam logic [KEY_LEN_W-1:0] KEY_LENGTH_RESET = 5'd16;

    typedef struct packed {
        logic [KEY_HALF_W-1:0] key_tail;
        logic [KEY_HALF_W-1:0] key_head;
        logic [KEY_LEN_W-1:0]  key_length;
    } key_cfg_t;

    typedef struct packed {
        logic [7:0] result_byte;
        logic       result_last;
    } result_t;

endpackage

FILE: src/rc4_core.sv
// ----------------------------------------------------------------------------
// rc4_core
// permutation memory and sequencer: key schedule and keystream generation
// ----------------------------------------------------------------------------
`include "rc4_keystream_cipher_macros.svh"

module rc4_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  rc4_pkg::key_cfg_t cfg,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        in_byte,
    input  logic              in_last,
    output logic              out_valid,
    input  logic              out_ready,
    output rc4_pkg::result_t  out_res
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FILL,
        ST_KS_RD_I,
        ST_KS_RD_J,
        ST_KS_WR_I,
        ST_KS_WR_J,
        ST_P_RD_I,
        ST_P_RD_J,
        ST_P_WR_I,
        ST_P_WR_J,
        ST_P_KS
    } state_t;

    // permutation memory
    logic [7:0] perm_mem [256];
    logic [7:0] rd_data_reg;
    logic       mem_we;
    logic [7:0] mem_waddr;
    logic [7:0] mem_wdata;
    logic       mem_re;
    logic [7:0] mem_raddr;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            perm_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= perm_mem[mem_raddr];
        end
    end

    state_t     state_reg, state_next;
    logic [7:0] n_reg, n_next;
    logic [3:0] kidx_reg, kidx_next;
    logic [7:0] i_reg, i_next;
    logic [7:0] j_reg, j_next;
    logic [7:0] si_reg, si_next;
    logic [7:0] sj_reg, sj_next;
    logic       hit_reg, hit_next;
    logic [7:0] msg_reg, msg_next;
    logic       last_reg, last_next;
    logic       keyed_reg, keyed_next;

    logic [127:0]         key_all;
    logic [7:0]           key_byte;
    logic [4:0]           len_eff;
    logic [7:0]           i_inc;
    logic [7:0]           j_sched;
    logic [7:0]           j_gen;
    logic [7:0]           t_addr;
    logic [7:0]           ks;

    assign key_all  = {cfg.key_tail, cfg.key_head};
    assign key_byte = key_all[{kidx_reg, 3'b000} +: 8];

    // zero counts as one byte, anything above the maximum saturates
    always_comb begin
        if (cfg.key_length == 5'd0) begin
            len_eff = 5'd1;
        end else if (cfg.key_length > 5'(rc4_pkg::MAX_KEY_BYTES)) begin
            len_eff = 5'(rc4_pkg::MAX_KEY_BYTES);
        end else begin
            len_eff = cfg.key_length;
        end
    end

    assign i_inc   = i_reg + 8'd1;
    assign j_sched = j_reg + rd_data_reg + key_byte;
    assign j_gen   = j_reg + rd_data_reg;
    assign t_addr  = si_reg + sj_reg;
    // output lookup that lands on the entry written in the same cycle
    assign ks      = hit_reg ? si_reg : rd_data_reg;

    assign in_ready            = (state_reg == ST_IDLE);
    assign out_valid           = (state_reg == ST_P_KS);
    assign out_res.result_byte = msg_reg ^ ks;
    assign out_res.result_last = last_reg;

    always_comb begin
        state_next = state_reg;
        n_next     = n_reg;
        kidx_next  = kidx_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        si_next    = si_reg;
        sj_next    = sj_reg;
        hit_next   = hit_reg;
        msg_next   = msg_reg;
        last_next  = last_reg;
        keyed_next = keyed_reg;
        mem_we     = 1'b0;
        mem_waddr  = n_reg;
        mem_wdata  = n_reg;
        mem_re     = 1'b0;
        mem_raddr  = n_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    msg_next  = in_byte;
                    last_next = in_last;
                    if (!keyed_reg) begin
                        n_next     = 8'd0;
                        state_next = ST_FILL;
                    end else begin
                        state_next = ST_P_RD_I;
                    end
                end
            end
            ST_FILL: begin
                mem_we = 1'b1;
                n_next = n_reg + 8'd1;
                if (n_reg == 8'hff) begin
                    j_next     = 8'd0;
                    kidx_next  = 4'd0;
                    state_next = ST_KS_RD_I;
                end
            end
            ST_KS_RD_I: begin
                mem_re     = 1'b1;
                state_next = ST_KS_RD_J;
            end
            ST_KS_RD_J: begin
                si_next    = rd_data_reg;
                j_next     = j_sched;
                mem_re     = 1'b1;
                mem_raddr  = j_sched;
                state_next = ST_KS_WR_I;
            end
            ST_KS_WR_I: begin
                mem_we     = 1'b1;
                mem_wdata  = rd_data_reg;
                state_next = ST_KS_WR_J;
            end
            ST_KS_WR_J: begin
                mem_we    = 1'b1;
                mem_waddr = j_reg;
                mem_wdata = si_reg;
                n_next    = n_reg + 8'd1;
                if (({1'b0, kidx_reg} + 5'd1) >= len_eff) begin
                    kidx_next = 4'd0;
                end else begin
                    kidx_next = kidx_reg + 4'd1;
                end
                if (n_reg == 8'hff) begin
                    i_next     = 8'd0;
                    j_next     = 8'd0;
                    keyed_next = 1'b1;
                    state_next = ST_P_RD_I;
                end else begin
                    state_next = ST_KS_RD_I;
                end
            end
            ST_P_RD_I: begin
                i_next     = i_inc;
                mem_re     = 1'b1;
                mem_raddr  = i_inc;
                state_next = ST_P_RD_J;
            end
            ST_P_RD_J: begin
                si_next    = rd_data_reg;
                j_next     = j_gen;
                mem_re     = 1'b1;
                mem_raddr  = j_gen;
                state_next = ST_P_WR_I;
            end
            ST_P_WR_I: begin
                sj_next    = rd_data_reg;
                mem_we     = 1'b1;
                mem_waddr  = i_reg;
                mem_wdata  = rd_data_reg;
                state_next = ST_P_WR_J;
            end
            ST_P_WR_J: begin
                mem_we     = 1'b1;
                mem_waddr  = j_reg;
                mem_wdata  = si_reg;
                mem_re     = 1'b1;
                mem_raddr  = t_addr;
                hit_next   = (t_addr == j_reg);
                state_next = ST_P_KS;
            end
            ST_P_KS: begin
                if (out_ready) begin
                    if (last_reg) begin
                        keyed_next = 1'b0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            i_reg     <= 8'd0;
            j_reg     <= 8'd0;
            keyed_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            keyed_reg <= keyed_next;
        end
        n_reg    <= n_next;
        kidx_reg <= kidx_next;
        si_reg   <= si_next;
        sj_reg   <= sj_next;
        hit_reg  <= hit_next;
        msg_reg  <= msg_next;
        last_reg <= last_next;
    end

    `RC4_ASSERT_NEXT(a_rekey_fill, in_valid && in_ready && !keyed_reg, state_reg == ST_FILL, "word accepted without key did not start fill")
    `RC4_ASSERT_NEXT(a_fill_end, state_reg == ST_FILL && n_reg == 8'hff, state_reg == ST_KS_RD_I, "fill did not hand over to key schedule")
    `RC4_ASSERT_IMPL(a_sched_done, state_reg == ST_P_RD_I, keyed_reg, "keystream step started with key schedule pending")
    `RC4_ASSERT_NEXT(a_last_rekeys, out_valid && out_ready && out_res.result_last, !keyed_reg && state_reg == ST_IDLE, "last word did not clear key state")

endmodule

FILE: src/rc4_keystream_cipher.sv
// ----------------------------------------------------------------------------
// rc4_keystream_cipher
// rc4 stream cipher: each message byte is xored with the next keystream byte
// ----------------------------------------------------------------------------
// usage:
//   s_ channel carries one message byte per word, s_tlast marks the final
//   byte of a message. m_ channel returns the byte xored with keystream,
//   m_tlast copies s_tlast. the key (key_head, key_tail, key_length) is set
//   through the cfg_ write port while the block is idle.
// sequencing:
//   the 256x8 permutation sits in one single-port-write, one-read memory
//   with registered read data; every access goes through that port, so
//   a keyed byte takes 5 sequencer steps plus the idle step before the
//   next byte can be accepted, the result entering the output register
//   as the core leaves its last step.
//   the first byte of a message first runs the key schedule: a fill of all
//   256 entries, then 256 swap steps of read i, read j, write i, write j.
// reset: indices clear, key_length returns to 16, the next byte rekeys.
// stall: a result waits in the output register; the core holds in its last
//   step until that register frees up, then goes back to accepting.
// ----------------------------------------------------------------------------
module rc4_keystream_cipher (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [rc4_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [rc4_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,   // [7:0] message_byte
    input  logic                                s_tlast,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [7:0]                          m_tdata,   // [7:0] result_byte
    output logic                                m_tlast
);

    logic [rc4_pkg::KEY_HALF_W-1:0] key_head_reg;
    logic [rc4_pkg::KEY_HALF_W-1:0] key_tail_reg;
    logic [rc4_pkg::KEY_LEN_W-1:0]  key_length_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_head_reg   <= '0;
            key_tail_reg   <= '0;
            key_length_reg <= rc4_pkg::KEY_LENGTH_RESET;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                rc4_pkg::REG_KEY_HEAD:   key_head_reg   <= cfg_wdata;
                rc4_pkg::REG_KEY_TAIL:   key_tail_reg   <= cfg_wdata;
                rc4_pkg::REG_KEY_LENGTH: key_length_reg <= cfg_wdata[rc4_pkg::KEY_LEN_W-1:0];
                default: ;
            endcase
        end
    end

    rc4_pkg::key_cfg_t cfg;
    rc4_pkg::result_t  core_res;
    logic              core_valid;
    logic              core_ready;

    assign cfg.key_head   = key_head_reg;
    assign cfg.key_tail   = key_tail_reg;
    assign cfg.key_length = key_length_reg;

    rc4_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_byte   (s_tdata),
        .in_last   (s_tlast),
        .out_valid (core_valid),
        .out_ready (core_ready),
        .out_res   (core_res)
    );

    // output register
    logic       m_valid_reg;
    logic [7:0] m_data_reg;
    logic       m_last_reg;

    assign core_ready = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (core_ready) begin
            m_valid_reg <= core_valid;
        end
        if (core_ready && core_valid) begin
            m_data_reg <= core_res.result_byte;
            m_last_reg <= core_res.result_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

endmodule
